@@ rtl/vcb_pkg.sv @@
// shared types and constants of the crossfade blend pipeline
// no dependencies; used by every module of the block
`default_nettype none

package vcb_pkg;

  localparam int CH       = 3;
  localparam int PIX_W    = 8;
  localparam int CNT_W    = 16;
  localparam int PROD_W   = PIX_W + CNT_W;
  localparam int DIV_W    = CNT_W + PIX_W - 1;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = PIX_W / DIV_STEPS;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [0:0] REG_FADE = 1'b0;
  localparam logic [CNT_W-1:0] FADE_RESET = CNT_W'(30);

  typedef enum logic [1:0] {
    PH_PASS  = 2'd0,
    PH_BLEND = 2'd1,
    PH_END   = 2'd2
  } phase_t;

  // channel 2 red, 1 green, 0 blue
  typedef logic [CH-1:0][PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t             a;
    pix_t             b;
    logic [CNT_W-1:0] a_left;
    logic [CNT_W-1:0] b_left;
  } in_word_t;

  typedef struct packed {
    pix_t             a;
    pix_t             b;
    logic [CNT_W-1:0] wa;
    logic [CNT_W-1:0] wb;
    logic [CNT_W-1:0] n;
    phase_t           phase;
    pix_t             byp;
  } prep_t;

  typedef struct packed {
    logic [CH-1:0][PROD_W-1:0] pa;
    logic [CH-1:0][PROD_W-1:0] pb;
    logic [CNT_W-1:0]          n;
    phase_t                    phase;
    pix_t                      byp;
  } mul_t;

  typedef struct packed {
    logic [CH-1:0][PROD_W-1:0] rem;
    logic [CH-1:0][PIX_W-1:0]  quo;
    logic [DIV_W-1:0]          d;
    phase_t                    phase;
    pix_t                      byp;
  } div_t;

endpackage

`default_nettype wire

@@ rtl/vcb_prep.sv @@
// first stage: phase decode and blend weights
// depends on vcb_pkg
`default_nettype none

module vcb_prep (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire vcb_pkg::in_word_t        in_word,
  input  wire logic [vcb_pkg::CNT_W-1:0] fade,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output vcb_pkg::prep_t                out_word
);

  vcb_pkg::prep_t word_next;

  always_comb begin
    logic [vcb_pkg::CNT_W-1:0] lmin;
    logic [vcb_pkg::CNT_W-1:0] r;
    lmin = (in_word.a_left < in_word.b_left) ? in_word.a_left : in_word.b_left;
    r    = lmin - vcb_pkg::CNT_W'(1);
    word_next.a  = in_word.a;
    word_next.b  = in_word.b;
    word_next.wa = r;
    word_next.wb = fade - r;
    word_next.n  = fade;
    if (in_word.a_left > fade) begin
      word_next.phase = vcb_pkg::PH_PASS;
      word_next.byp   = in_word.a;
    end else if (in_word.a_left != '0 && in_word.b_left != '0) begin
      word_next.phase = vcb_pkg::PH_BLEND;
      word_next.byp   = '0;
    end else begin
      word_next.phase = vcb_pkg::PH_END;
      word_next.byp   = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/vcb_mul.sv @@
// weight multiply stage and channel sum stage
// depends on vcb_pkg
`default_nettype none

module vcb_mul (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire vcb_pkg::prep_t in_word,
  output logic                out_valid,
  input  wire logic           out_ready,
  output vcb_pkg::div_t       out_word
);

  vcb_pkg::mul_t mul;
  logic          mul_valid;
  logic          mul_ready;
  vcb_pkg::mul_t mul_next;
  vcb_pkg::div_t sum_next;

  always_comb begin
    for (int c = 0; c < vcb_pkg::CH; c++) begin
      mul_next.pa[c] = vcb_pkg::PROD_W'(in_word.a[c]) * vcb_pkg::PROD_W'(in_word.wa);
      mul_next.pb[c] = vcb_pkg::PROD_W'(in_word.b[c]) * vcb_pkg::PROD_W'(in_word.wb);
    end
    mul_next.n     = in_word.n;
    mul_next.phase = in_word.phase;
    mul_next.byp   = in_word.byp;
  end

  always_comb begin
    for (int c = 0; c < vcb_pkg::CH; c++) begin
      sum_next.rem[c] = mul.pa[c] + mul.pb[c];
    end
    sum_next.quo   = '0;
    sum_next.d     = {mul.n, (vcb_pkg::PIX_W-1)'(0)};
    sum_next.phase = mul.phase;
    sum_next.byp   = mul.byp;
  end

  assign in_ready  = !mul_valid || mul_ready;
  assign mul_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        mul_valid <= in_valid;
      end
      if (mul_ready) begin
        out_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mul <= mul_next;
    end
    if (mul_ready && mul_valid) begin
      out_word <= sum_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/vcb_div_stage.sv @@
// one stage of the restoring divider, two quotient bits per stage
// depends on vcb_pkg
`default_nettype none

module vcb_div_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire vcb_pkg::div_t in_word,
  output logic               out_valid,
  input  wire logic          out_ready,
  output vcb_pkg::div_t      out_word
);

  vcb_pkg::div_t word_next;

  always_comb begin
    word_next = in_word;
    for (int k = 0; k < vcb_pkg::DIV_STEPS; k++) begin
      for (int c = 0; c < vcb_pkg::CH; c++) begin
        if (word_next.rem[c] >= vcb_pkg::PROD_W'(word_next.d)) begin
          word_next.rem[c] = word_next.rem[c] - vcb_pkg::PROD_W'(word_next.d);
          word_next.quo[c] = {word_next.quo[c][vcb_pkg::PIX_W-2:0], 1'b1};
        end else begin
          word_next.quo[c] = {word_next.quo[c][vcb_pkg::PIX_W-2:0], 1'b0};
        end
      end
      word_next.d = word_next.d >> 1;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/video_crossfade_blend.sv @@
// top level of the crossfade blend: register port, pipeline, result select
// depends on vcb_pkg, vcb_prep, vcb_mul, vcb_div_stage
//
//   channel  handshake          word
//   in       in_valid/in_stall  a_*, b_* bytes, a_frames_left, b_frames_left
//   out      out_valid/out_stall out_red, out_green, out_blue, phase
//   config   apb psel/penable   fade_frames at byte address 0
//
// one word per cycle sustained while out_stall is low; registered stages are decode,
// multiply, sum, then four divider stages of two quotient bits each
// each stage holds its own valid bit and takes a word when it is empty or
// its follower moves, so bubbles close up while the output is stalled
// synchronous reset clears all valid bits and sets fade_frames to 30
`default_nettype none

module video_crossfade_blend (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [vcb_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [vcb_pkg::DATA_W-1:0]  pwdata,
  output logic      [vcb_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [vcb_pkg::PIX_W-1:0]   a_red,
  input  wire logic [vcb_pkg::PIX_W-1:0]   a_green,
  input  wire logic [vcb_pkg::PIX_W-1:0]   a_blue,
  input  wire logic [vcb_pkg::PIX_W-1:0]   b_red,
  input  wire logic [vcb_pkg::PIX_W-1:0]   b_green,
  input  wire logic [vcb_pkg::PIX_W-1:0]   b_blue,
  input  wire logic [vcb_pkg::CNT_W-1:0]   a_frames_left,
  input  wire logic [vcb_pkg::CNT_W-1:0]   b_frames_left,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [vcb_pkg::PIX_W-1:0]   out_red,
  output logic      [vcb_pkg::PIX_W-1:0]   out_green,
  output logic      [vcb_pkg::PIX_W-1:0]   out_blue,
  output logic      [1:0]                  phase
);

  logic [vcb_pkg::CNT_W-1:0] fade_frames;
  logic                      reg_hit;
  vcb_pkg::in_word_t         in_word;
  logic                      in_ready;
  vcb_pkg::prep_t            prep_word;
  logic                      prep_valid;
  logic                      prep_ready;
  vcb_pkg::div_t             div_word  [vcb_pkg::DIV_STAGES+1];
  logic                      div_valid [vcb_pkg::DIV_STAGES+1];
  logic                      div_ready [vcb_pkg::DIV_STAGES+1];
  vcb_pkg::div_t             last;

  // register port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[vcb_pkg::ADDR_W-1:2] == vcb_pkg::REG_FADE);
  assign prdata  = reg_hit ? vcb_pkg::DATA_W'(fade_frames) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_frames <= vcb_pkg::FADE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      fade_frames <= pwdata[vcb_pkg::CNT_W-1:0];
    end
  end

  // pipeline
  assign in_word.a      = {a_red, a_green, a_blue};
  assign in_word.b      = {b_red, b_green, b_blue};
  assign in_word.a_left = a_frames_left;
  assign in_word.b_left = b_frames_left;
  assign in_stall       = !in_ready;

  vcb_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .fade      (fade_frames),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_word  (prep_word)
  );

  vcb_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_word   (prep_word),
    .out_valid (div_valid[0]),
    .out_ready (div_ready[0]),
    .out_word  (div_word[0])
  );

  for (genvar s = 0; s < vcb_pkg::DIV_STAGES; s++) begin : g_div
    vcb_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[s]),
      .in_ready  (div_ready[s]),
      .in_word   (div_word[s]),
      .out_valid (div_valid[s+1]),
      .out_ready (div_ready[s+1]),
      .out_word  (div_word[s+1])
    );
  end

  // result select
  assign last = div_word[vcb_pkg::DIV_STAGES];
  assign div_ready[vcb_pkg::DIV_STAGES] = !out_stall;
  assign out_valid = div_valid[vcb_pkg::DIV_STAGES];
  assign phase     = last.phase;

  always_comb begin
    vcb_pkg::pix_t px;
    if (last.phase == vcb_pkg::PH_BLEND) begin
      px = last.quo;
    end else begin
      px = last.byp;
    end
    out_red   = px[2];
    out_green = px[1];
    out_blue  = px[0];
  end

endmodule

`default_nettype wire
